@@ src/wpc_pkg.sv @@
package wpc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAME_BITS  = 32;
  localparam int COL_BITS    = 13;
  localparam int MAX_COLUMNS = 4096;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [COL_BITS-1:0] COL_LIMIT = COL_BITS'(MAX_COLUMNS);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_FRAME_TOTAL   = 2'd0,
    REG_COLUMN_TOTAL  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_START,
    S_DIV
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_ch0;
    logic signed [SAMPLE_BITS-1:0] sample_ch1;
  } in_word_t;

  typedef struct packed {
    logic [11:0]                   column_first;
    logic [COL_BITS-1:0]           column_repeat;
    logic signed [SAMPLE_BITS-1:0] peak_min;
    logic signed [SAMPLE_BITS-1:0] peak_max;
    logic                          build_done;
  } out_word_t;

  // settings seen by the sequencer
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_total;
    logic [COL_BITS-1:0]   w_eff;
    logic                  two_ch;
    logic                  active;
    logic                  restart;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [FRAME_BITS-1:0] dividend;
    logic [COL_BITS-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [FRAME_BITS-1:0] quot;
    logic [COL_BITS-1:0]   rem;
  } div_res_t;

endpackage

@@ src/waveform_peak_column_builder.sv @@
// Frame that closes no column: accepted, and the next frame may follow at once.
// Frame that closes columns: one boundary step per column in the shared add/compare
// stepper, then the result word is registered once the output is free.
// A write to any of the three registers restarts the build: if active, T/W is
// recomputed by a bit-serial divider while in_stall is high. Reset (rst_n low,
// synchronous) leaves the block idle with no columns; frames are taken and dropped.
module waveform_peak_column_builder import wpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t     cfg;
  div_req_t div_req;
  div_res_t div_res;

  wpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  state_t st_r, st_nxt;

  logic [FRAME_BITS-1:0]         frame_pos_r, frame_pos_nxt;
  logic [COL_BITS-1:0]           col_pos_r, col_pos_nxt;
  logic [COL_BITS-1:0]           first_r, first_nxt;
  logic [FRAME_BITS:0]           col_end_r, col_end_nxt;
  logic [FRAME_BITS:0]           done_at_r, done_at_nxt;
  logic [FRAME_BITS:0]           q_r, q_nxt;
  logic [COL_BITS-1:0]           r_r, r_nxt;
  logic [FRAME_BITS-1:0]         qstep_r, qstep_nxt;
  logic [COL_BITS-1:0]           rstep_r, rstep_nxt;
  logic                          qzero_r, qzero_nxt;
  logic signed [SAMPLE_BITS-1:0] run_min_r, run_min_nxt;
  logic signed [SAMPLE_BITS-1:0] run_max_r, run_max_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_word_t                     out_data_r, out_data_nxt;

  logic                          in_acc;
  logic                          live;
  logic                          out_free;
  logic                          load_out;
  logic [FRAME_BITS:0]           done_at;
  logic signed [SAMPLE_BITS-1:0] mn0, mx0, mn1, mx1;

  // boundary stepper: (q, r) = divmod((k+1)T, W), stepped by (T/W, T%W)
  logic [COL_BITS:0]             r_sum;
  logic                          carry;
  logic [COL_BITS-1:0]           r_adv;
  logic [FRAME_BITS:0]           q_adv;
  logic [FRAME_BITS:0]           end_adv;

  always_comb begin
    r_sum = {1'b0, r_r} + {1'b0, rstep_r};
    carry = (r_sum >= {1'b0, cfg.w_eff});
    r_adv = carry ? COL_BITS'(r_sum - {1'b0, cfg.w_eff}) : r_sum[COL_BITS-1:0];
    q_adv = q_r + {1'b0, qstep_r} + (FRAME_BITS+1)'(carry);
    // a column holds at least one frame
    end_adv = (qzero_r && !carry) ? (q_r + 1'b1) : q_adv;
  end

  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign live     = cfg.active && (col_pos_r < cfg.w_eff);
  assign out_free = !out_valid_r || !out_stall;
  assign done_at  = {1'b0, frame_pos_r} + 1'b1;

  always_comb begin
    mn0 = (in_data.sample_ch0 < run_min_r) ? in_data.sample_ch0 : run_min_r;
    mx0 = (in_data.sample_ch0 > run_max_r) ? in_data.sample_ch0 : run_max_r;
    mn1 = (cfg.two_ch && (in_data.sample_ch1 < mn0)) ? in_data.sample_ch1 : mn0;
    mx1 = (cfg.two_ch && (in_data.sample_ch1 > mx0)) ? in_data.sample_ch1 : mx0;
  end

  always_comb begin
    st_nxt        = st_r;
    frame_pos_nxt = frame_pos_r;
    col_pos_nxt   = col_pos_r;
    first_nxt     = first_r;
    col_end_nxt   = col_end_r;
    done_at_nxt   = done_at_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    qstep_nxt     = qstep_r;
    rstep_nxt     = rstep_r;
    qzero_nxt     = qzero_r;
    run_min_nxt   = run_min_r;
    run_max_nxt   = run_max_r;
    out_data_nxt  = out_data_r;
    load_out      = 1'b0;

    div_req.start    = 1'b0;
    div_req.dividend = cfg.frame_total;
    div_req.divisor  = cfg.w_eff;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc && live) begin
          run_min_nxt   = mn1;
          run_max_nxt   = mx1;
          frame_pos_nxt = done_at[FRAME_BITS-1:0];
          if (col_end_r == done_at) begin
            done_at_nxt = done_at;
            first_nxt   = col_pos_r;
            col_pos_nxt = col_pos_r + 1'b1;
            q_nxt       = q_adv;
            r_nxt       = r_adv;
            col_end_nxt = end_adv;
            st_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // further single-frame columns closing on the same frame
        if ((col_pos_r < cfg.w_eff) && (col_end_r == done_at_r)) begin
          col_pos_nxt = col_pos_r + 1'b1;
          q_nxt       = q_adv;
          r_nxt       = r_adv;
          col_end_nxt = end_adv;
        end else if (out_free) begin
          load_out                   = 1'b1;
          out_data_nxt.column_first  = first_r[11:0];
          out_data_nxt.column_repeat = col_pos_r - first_r;
          out_data_nxt.peak_min      = run_min_r;
          out_data_nxt.peak_max      = run_max_r;
          out_data_nxt.build_done    = (col_pos_r >= cfg.w_eff);
          run_min_nxt                = SAMPLE_POS;
          run_max_nxt                = SAMPLE_NEG;
          st_nxt                     = S_IDLE;
        end
      end
      S_START: begin
        if (cfg.active) begin
          div_req.start = 1'b1;
          st_nxt        = S_DIV;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          qstep_nxt   = div_res.quot;
          rstep_nxt   = div_res.rem;
          qzero_nxt   = (div_res.quot == '0);
          q_nxt       = {1'b0, div_res.quot};
          r_nxt       = div_res.rem;
          col_end_nxt = (div_res.quot == '0) ? (FRAME_BITS+1)'(1) : {1'b0, div_res.quot};
          st_nxt      = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (cfg.restart) begin
      st_nxt        = S_START;
      frame_pos_nxt = '0;
      col_pos_nxt   = '0;
      col_end_nxt   = '0;
      run_min_nxt   = SAMPLE_POS;
      run_max_nxt   = SAMPLE_NEG;
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      frame_pos_r <= '0;
      col_pos_r   <= '0;
      col_end_r   <= '0;
      run_min_r   <= SAMPLE_POS;
      run_max_r   <= SAMPLE_NEG;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      frame_pos_r <= frame_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      col_end_r   <= col_end_nxt;
      run_min_r   <= run_min_nxt;
      run_max_r   <= run_max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r    <= first_nxt;
    done_at_r  <= done_at_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    qstep_r    <= qstep_nxt;
    rstep_r    <= rstep_nxt;
    qzero_r    <= qzero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_pos_r <= cfg.w_eff)
    else $error("column position past column count");

  a_repeat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid && (out_data.column_repeat != '0))
    else $error("result word with zero repeat");

  a_peaks_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (run_min_r == SAMPLE_POS) && (run_max_r == SAMPLE_NEG))
    else $error("running peaks not cleared after result");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && live && !cfg.restart) |=> (run_min_r <= run_max_r))
    else $error("running min above running max after a frame");

endmodule

@@ src/wpc_div.sv @@
module wpc_div import wpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  localparam int CNT_BITS = $clog2(FRAME_BITS);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [FRAME_BITS-1:0] dvd_r;
  logic [COL_BITS-1:0]   rem_r;

  logic [COL_BITS:0]     shifted;
  logic                  qbit;
  logic [COL_BITS:0]     rem_nxt;

  // one restoring step per cycle: quotient bits shift into the dividend register
  always_comb begin
    shifted = {rem_r, dvd_r[FRAME_BITS-1]};
    qbit    = (shifted >= {1'b0, req.divisor});
    rem_nxt = qbit ? (shifted - {1'b0, req.divisor}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(FRAME_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[FRAME_BITS-2:0], qbit};
      rem_r <= rem_nxt[COL_BITS-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quot = dvd_r;
  assign res.rem  = rem_r;

endmodule

@@ src/wpc_cfg.sv @@
module wpc_cfg import wpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [FRAME_BITS-1:0] frame_total_r;
  logic [COL_BITS-1:0]   column_total_r;
  logic [1:0]            channel_count_r;

  logic     wr;
  logic     hit;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    hit    = 1'b0;
    prdata = '0;
    unique case (idx)
      REG_FRAME_TOTAL: begin
        hit    = 1'b1;
        prdata = DATA_BITS'(frame_total_r);
      end
      REG_COLUMN_TOTAL: begin
        hit    = 1'b1;
        prdata = DATA_BITS'(column_total_r);
      end
      REG_CHANNEL_COUNT: begin
        hit    = 1'b1;
        prdata = DATA_BITS'(channel_count_r);
      end
      default: begin
        hit    = 1'b0;
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_total_r   <= '0;
      column_total_r  <= '0;
      channel_count_r <= 2'd1;
    end else if (wr) begin
      unique case (idx)
        REG_FRAME_TOTAL:   frame_total_r   <= pwdata[FRAME_BITS-1:0];
        REG_COLUMN_TOTAL:  column_total_r  <= pwdata[COL_BITS-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.frame_total = frame_total_r;
    cfg.w_eff       = (column_total_r > COL_LIMIT) ? COL_LIMIT : column_total_r;
    cfg.two_ch      = channel_count_r[1];
    cfg.active      = (frame_total_r != '0) && (column_total_r != '0) &&
                      (channel_count_r != 2'd0);
    cfg.restart     = wr && hit;
  end

endmodule
